// ===== hdl/mhs_pkg.sv =====
`timescale 1ns / 1ps

package mhs_pkg;

  // Sample and weight formats
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;              // weights are scaled by 2^16
  localparam int WGT_BITS    = FRAC_BITS + 2;   // holds +1.0 as a signed value
  localparam int PROD_BITS   = SAMPLE_BITS + WGT_BITS;
  localparam int SUM_BITS    = PROD_BITS + 2;   // three products

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [WGT_BITS-1:0]    wgt_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  // Window valid pattern: bit 0 older, bit 1 center, bit 2 newest
  typedef logic [2:0] valid_case_t;

  localparam valid_case_t VC_NONE          = 3'b000;
  localparam valid_case_t VC_OLDER         = 3'b001;
  localparam valid_case_t VC_CENTER        = 3'b010;
  localparam valid_case_t VC_OLDER_CENTER  = 3'b011;
  localparam valid_case_t VC_NEWEST        = 3'b100;
  localparam valid_case_t VC_OLDER_NEWEST  = 3'b101;
  localparam valid_case_t VC_CENTER_NEWEST = 3'b110;
  localparam valid_case_t VC_ALL           = 3'b111;

  // Renormalized weights, each set but VC_NONE sums to exactly 1.0
  localparam wgt_t W_ZERO       = WGT_BITS'(0);
  localparam wgt_t W_ONE        = WGT_BITS'(65536);
  localparam wgt_t W_HALF       = WGT_BITS'(32768);
  localparam wgt_t W_QUARTER    = WGT_BITS'(16384);
  localparam wgt_t W_THIRD      = WGT_BITS'(21845);
  localparam wgt_t W_TWO_THIRDS = WGT_BITS'(43691);

  // Rounding offset: half an output LSB
  localparam sum_t ROUND_HALF = SUM_BITS'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    wgt_t older;
    wgt_t center;
    wgt_t newest;
  } tap_wgt_t;

  function automatic tap_wgt_t tap_weights(valid_case_t vc);
    tap_wgt_t w;
    unique case (vc)
      VC_NONE:          w = '{W_ZERO,       W_ZERO,       W_ZERO};
      VC_OLDER:         w = '{W_ONE,        W_ZERO,       W_ZERO};
      VC_CENTER:        w = '{W_ZERO,       W_ONE,        W_ZERO};
      VC_OLDER_CENTER:  w = '{W_THIRD,      W_TWO_THIRDS, W_ZERO};
      VC_NEWEST:        w = '{W_ZERO,       W_ZERO,       W_ONE};
      VC_OLDER_NEWEST:  w = '{W_HALF,       W_ZERO,       W_HALF};
      VC_CENTER_NEWEST: w = '{W_ZERO,       W_TWO_THIRDS, W_THIRD};
      VC_ALL:           w = '{W_QUARTER,    W_HALF,       W_QUARTER};
      default:          w = '{W_ZERO,       W_ZERO,       W_ZERO};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/masked_hanning_smoother.sv =====
`timescale 1ns / 1ps

// Masked 3-tap Hanning smoother. Takes one spectral sample per cycle while
// in_stall is low, with its mask bit, and emits one smoothed word per
// interior channel: the first and last channels of a spectrum (in_last marks
// the last) give no word, so spectra shorter than three channels give
// nothing. Weights are 1/4,1/2,1/4, renormalized over the unmasked taps;
// masked results carry 0. With cfg_wr_data = 1 (all_valid_only) a word is
// valid only if all three taps are unmasked. Throughput is one word per
// cycle while out_stall is low; a result passes from the product register,
// loaded by the three weight multipliers when its input word is taken, to
// the output register, loaded from the sum and rounding. Write the
// configuration only while the block is idle.
module masked_hanning_smoother import mhs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  // sample input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_sample_valid,
  input  logic                          in_last,
  // smoothed output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_smoothed,
  output logic                          out_smoothed_valid,
  output logic                          out_frame_end
);

  // Configuration
  logic all_valid_only_r;

  // Window history
  sample_t    prev_sample_r, older_sample_r;
  logic       prev_valid_r, older_valid_r;
  logic [1:0] fill_count_r;

  // Product stage
  logic  s1_vld_r;
  prod_t p_older_r, p_center_r, p_newest_r;
  logic  s1_ok_r, s1_last_r;

  // Output register
  logic    out_valid_r;
  sample_t out_smoothed_r;
  logic    out_ok_r, out_last_r;

  // Flow control
  logic out_ready, s1_ready, in_accept, win_full;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_vld_r || out_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;
  assign win_full  = fill_count_r[1];

  // Case decode and weight selection
  valid_case_t vc;
  logic        ok;
  tap_wgt_t    wgt;

  always_comb begin
    vc  = {in_sample_valid, prev_valid_r, older_valid_r};
    ok  = all_valid_only_r ? (vc == VC_ALL) : (vc != VC_NONE);
    // masked result: zero weights give zero products and a zero result
    wgt = ok ? tap_weights(vc) : tap_weights(VC_NONE);
  end

  // Sum of products with round-half-up, then drop the fraction
  sum_t sum;
  always_comb begin
    sum = SUM_BITS'(p_older_r) + SUM_BITS'(p_center_r) + SUM_BITS'(p_newest_r)
        + ROUND_HALF;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_valid_only_r <= 1'b0;
    end else if (cfg_wr_en) begin
      all_valid_only_r <= cfg_wr_data;
    end
  end

  // Window history and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r  <= 1'b0;
      older_valid_r <= 1'b0;
      fill_count_r  <= 2'd0;
    end else if (in_accept) begin
      older_valid_r <= prev_valid_r;
      prev_valid_r  <= in_sample_valid;
      if (in_last) begin
        fill_count_r <= 2'd0;
      end else if (!win_full) begin
        fill_count_r <= fill_count_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      older_sample_r <= prev_sample_r;
      prev_sample_r  <= in_sample;
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_r <= in_accept && win_full;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p_older_r  <= PROD_BITS'(older_sample_r) * PROD_BITS'(wgt.older);
      p_center_r <= PROD_BITS'(prev_sample_r) * PROD_BITS'(wgt.center);
      p_newest_r <= PROD_BITS'(in_sample) * PROD_BITS'(wgt.newest);
      s1_ok_r    <= ok;
      s1_last_r  <= in_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_vld_r) begin
      out_smoothed_r <= sum[FRAC_BITS +: SAMPLE_BITS];
      out_ok_r       <= s1_ok_r;
      out_last_r     <= s1_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed       = out_smoothed_r;
  assign out_smoothed_valid = out_ok_r;
  assign out_frame_end      = out_last_r;

endmodule

// ===== sim/masked_hanning_smoother_test.sv =====
`timescale 1ns / 1ps

module masked_hanning_smoother_test;
  import mhs_pkg::*;

  localparam int  DRAIN_CYCLES = 6;       // pipeline is two deep, leave margin
  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  HOLD_CYCLES  = 80;

  // Renormalized tap weights, scaled by 2^16
  localparam longint WT_ONE        = 65536;
  localparam longint WT_HALF       = 32768;
  localparam longint WT_QUARTER    = 16384;
  localparam longint WT_THIRD      = 21845;
  localparam longint WT_TWO_THIRDS = 43691;

  typedef struct {
    sample_t smoothed;
    logic    smoothed_valid;
    logic    frame_end;
  } smooth_word_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cfg_wr_en = 1'b0;
  logic    cfg_wr_data = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_sample = '0;
  logic    in_sample_valid = 1'b0;
  logic    in_last = 1'b0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_smoothed;
  logic    out_smoothed_valid;
  logic    out_frame_end;

  // Window model: center is the previous word, older the one before it
  sample_t window_older = '0;
  sample_t window_center = '0;
  logic    older_ok = 1'b0;
  logic    center_ok = 1'b0;
  int      held_count = 0;
  logic    strict_mode = 1'b0;

  smooth_word_t expected_words[$];
  smooth_word_t head;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int words_sent = 0;
  int words_checked = 0;
  int errors = 0;
  int cycles = 0;

  masked_hanning_smoother dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_sample_valid    (in_sample_valid),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_smoothed       (out_smoothed),
    .out_smoothed_valid (out_smoothed_valid),
    .out_frame_end      (out_frame_end)
  );

  always #5 clk = ~clk;

  // Run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycles, expected_words.size());
      $display("FAIL masked_hanning_smoother");
      $finish;
    end
  end

  // Receiver back-pressure: a requested hold first, random stalls otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: smoothed %0d valid %0b frame_end %0b",
               out_smoothed, out_smoothed_valid, out_frame_end);
        errors++;
      end else begin
        head = expected_words.pop_front();
        words_checked++;
        if (out_smoothed !== head.smoothed) begin
          $error("smoothed: expected %0d, got %0d", head.smoothed, out_smoothed);
          errors++;
        end
        if (out_smoothed_valid !== head.smoothed_valid) begin
          $error("smoothed_valid: expected %0b, got %0b",
                 head.smoothed_valid, out_smoothed_valid);
          errors++;
        end
        if (out_frame_end !== head.frame_end) begin
          $error("frame_end: expected %0b, got %0b", head.frame_end, out_frame_end);
          errors++;
        end
      end
    end
  end

  // Advance the smoothing window by one accepted word, queue any result
  function automatic void advance_window(sample_t s, logic s_ok, logic lst);
    valid_case_t  vc;
    longint       w_o;
    longint       w_c;
    longint       w_n;
    longint       acc;
    longint       rounded;
    smooth_word_t r;
    if (held_count >= 2) begin
      vc = {s_ok, center_ok, older_ok};
      w_o = 0;
      w_c = 0;
      w_n = 0;
      case (vc)
        VC_OLDER:         w_o = WT_ONE;
        VC_CENTER:        w_c = WT_ONE;
        VC_OLDER_CENTER: begin
          w_o = WT_THIRD;
          w_c = WT_TWO_THIRDS;
        end
        VC_NEWEST:        w_n = WT_ONE;
        VC_OLDER_NEWEST: begin
          w_o = WT_HALF;
          w_n = WT_HALF;
        end
        VC_CENTER_NEWEST: begin
          w_c = WT_TWO_THIRDS;
          w_n = WT_THIRD;
        end
        VC_ALL: begin
          w_o = WT_QUARTER;
          w_c = WT_HALF;
          w_n = WT_QUARTER;
        end
        default: ;
      endcase
      r.smoothed_valid = strict_mode ? (vc == VC_ALL) : (vc != VC_NONE);
      r.frame_end = lst;
      r.smoothed = '0;
      if (r.smoothed_valid) begin
        acc = w_o * longint'(window_older) + w_c * longint'(window_center)
            + w_n * longint'(s);
        // round half up, then guard the range
        rounded = (acc + 32768) >>> 16;
        if (rounded > 32767) rounded = 32767;
        if (rounded < -32768) rounded = -32768;
        r.smoothed = sample_t'(rounded);
      end
      expected_words.push_back(r);
    end
    window_older = window_center;
    older_ok = center_ok;
    window_center = s;
    center_ok = s_ok;
    if (lst) held_count = 0;
    else if (held_count < 2) held_count++;
  endfunction

  // Offer one word, with random idle cycles ahead of it, until accepted
  task automatic send_word(sample_t s, logic s_ok, logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_sample_valid <= s_ok;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_window(s, s_ok, lst);
    words_sent++;
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  // Wait until every expected word is back, then let the pipeline settle
  task automatic wait_drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic strict);
    release_input();
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= strict;
    @(posedge clk);
    strict_mode = strict;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    int kind;
    int v;
    kind = $urandom_range(3);
    case (kind)
      0: v = $urandom_range(8) - 4;     // rounding ties live here
      1: begin
        v = $urandom_range(3);
        v = (v == 0) ? 32767 : (v == 1) ? -32768 : (v == 2) ? -1 : 0;
      end
      default: v = $urandom();
    endcase
    return sample_t'(v);
  endfunction

  // Spectra shorter than three channels give nothing
  task automatic test_short_spectra();
    send_word(sample_t'(5), 1'b1, 1'b1);
    send_word(sample_t'(-7), 1'b1, 1'b0);
    send_word(sample_t'(9), 1'b0, 1'b1);
    release_input();
    wait_drain();
  endtask

  // Mask bits 0001110100 walk the window through all eight valid cases
  task automatic test_mask_patterns(logic strict);
    logic    mask_bits[10] = '{0, 0, 0, 1, 1, 1, 0, 1, 0, 0};
    sample_t vals[10] = '{32767, -32768, 1, 32767, 32767, -32768, -32768,
                          -1, 32767, 1};
    write_mode(strict);
    for (int i = 0; i < 10; i++) begin
      send_word(strict ? ~vals[i] : vals[i], mask_bits[i], i == 9);
    end
    release_input();
    wait_drain();
  endtask

  // Random spectra; mostly full length, some too short to give results
  task automatic send_random_spectra(int n_words);
    int count;
    int len;
    int density;
    logic ok;
    count = 0;
    while (count < n_words) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      density = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
        case (density)
          0: ok = 1'b1;
          1: ok = ($urandom_range(99) < 80);
          2: ok = 1'($urandom_range(1));
          default: ok = ($urandom_range(99) < 20);
        endcase
        send_word(pick_sample(), ok, i == len - 1);
        count++;
      end
    end
  endtask

  task automatic test_random_phases();
    int idle_set[4]  = '{0, 88, 0, 37};
    int stall_set[4] = '{0, 0, 88, 37};
    for (int p = 0; p < 4; p++) begin
      for (int m = 1; m >= 0; m--) begin
        write_mode(m[0]);
        idle_pct = idle_set[p];
        stall_pct = stall_set[p];
        send_random_spectra(52);
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure_hold();
    write_mode(1'b0);
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    @(posedge clk);
    send_random_spectra(40);
    release_input();
    wait_drain();
  endtask

  // Sender stops mid-spectrum until every result is back, then resumes
  task automatic test_pause_drain();
    stall_pct = 37;
    for (int i = 0; i < 4; i++) send_word(pick_sample(), 1'b1, 1'b0);
    release_input();
    wait_drain();
    for (int i = 0; i < 4; i++) send_word(pick_sample(), 1'($urandom_range(1)), i == 3);
    release_input();
    wait_drain();
    stall_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_spectra();
    test_mask_patterns(1'b0);
    test_mask_patterns(1'b1);
    test_random_phases();
    test_backpressure_hold();
    test_pause_drain();
    release_input();
    wait_drain();
    $display("Sent %0d words in strict and relaxed masking, checked %0d results,",
             words_sent, words_checked);
    $display("under free flow, sender gaps, receiver stalls and a long hold-off.");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS masked_hanning_smoother");
    end else begin
      $display("FAIL masked_hanning_smoother");
    end
    $finish;
  end

endmodule
